// ===== design/mrrs_pkg.sv =====
// Shared types, constants and lookup functions for the motor register
// read-back sequencer. No dependencies; used by every module of the block.
`default_nettype none

package mrrs_pkg;

    localparam int NUM_MOTORS      = 6;
    localparam int NUM_POLLED_REGS = 45;
    localparam int MIRROR_DEPTH    = NUM_MOTORS * NUM_POLLED_REGS;
    localparam int MIR_AW          = $clog2(MIRROR_DEPTH);
    localparam int MOTOR_W         = 3;
    localparam int STEP_W          = 6;
    localparam int SLOT_W          = 6;
    localparam int ID_W            = 11;
    localparam int WORD_W          = 32;

    // command codes carried in tuser
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // configuration register indexes
    localparam logic CFG_FEEDBACK_BASE = 1'b0;
    localparam logic CFG_COMMAND_BASE  = 1'b1;

    localparam logic [ID_W-1:0] FEEDBACK_BASE_RST = 11'h020;
    localparam logic [ID_W-1:0] COMMAND_BASE_RST  = 11'h010;

    localparam logic [7:0] REPLY_CODE = 8'h33;
    localparam logic [3:0] FRAME_DLC  = 4'd8;

    localparam logic [7:0] REG_LOW_LAST   = 8'd36;
    localparam logic [7:0] REG_MID_FIRST  = 8'd50;
    localparam logic [7:0] REG_MID_LAST   = 8'd55;
    localparam logic [7:0] REG_HIGH_FIRST = 8'd80;
    localparam logic [7:0] REG_LAST       = 8'd81;

    localparam logic [SLOT_W-1:0] SLOT_HIGH_FIRST = SLOT_W'(43);
    localparam logic [SLOT_W-1:0] SLOT_LAST       = SLOT_W'(NUM_POLLED_REGS - 1);
    localparam logic [STEP_W-1:0] STEP_DONE       = '0;
    localparam logic [STEP_W-1:0] STEP_FIRST      = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(NUM_POLLED_REGS);

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ID_W-1:0]    frame_ident;
        logic               frame_is_standard;
        logic               frame_is_data;
        logic [3:0]         frame_length;
        logic [7:0]         command_byte;
        logic [7:0]         register_number;
        logic [WORD_W-1:0]  payload_word;
        logic [MOTOR_W-1:0] motor_sel;
    } item_t;

    typedef struct packed {
        logic              en;
        logic [MIR_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } mir_wr_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] can_id;
        logic [7:0]      reg_num;
    } req_t;

    // {known, slot} of a register number
    function automatic logic [SLOT_W:0] slot_lookup(input logic [7:0] r);
        logic [SLOT_W:0] res;
        res = '0;
        if (r <= REG_LOW_LAST)
            res = {1'b1, r[SLOT_W-1:0]};
        else if (r >= REG_MID_FIRST && r <= REG_MID_LAST)
            res = {1'b1, SLOT_W'(r - 8'd13)};
        else if (r == REG_HIGH_FIRST)
            res = {1'b1, SLOT_HIGH_FIRST};
        else if (r == REG_LAST)
            res = {1'b1, SLOT_LAST};
        return res;
    endfunction

    // register requested at sweep step 1..45
    function automatic logic [7:0] register_of_step(input logic [STEP_W-1:0] s);
        logic [7:0] r;
        if (s <= STEP_W'(37))
            r = 8'(s) - 8'd1;
        else if (s <= STEP_W'(43))
            r = 8'(s) + 8'd12;
        else
            r = 8'(s) + 8'd36;
        return r;
    endfunction

    function automatic logic [MIR_AW-1:0] mirror_addr(input logic [MOTOR_W-1:0] m,
                                                      input logic [SLOT_W-1:0] s);
        return MIR_AW'(m) * MIR_AW'(NUM_POLLED_REGS) + MIR_AW'(s);
    endfunction

endpackage

`default_nettype wire

// ===== design/mrrs_mirror_ram.sv =====
// Register mirror storage: one write port, one read port, registered read data.
// Depends on mrrs_pkg for depth and widths.
`default_nettype none

module mrrs_mirror_ram (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [mrrs_pkg::MIR_AW-1:0]   wr_addr,
    input  wire logic [mrrs_pkg::WORD_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [mrrs_pkg::MIR_AW-1:0]   rd_addr,
    output logic      [mrrs_pkg::WORD_W-1:0]   rd_data
);

    logic [mrrs_pkg::WORD_W-1:0] mem [mrrs_pkg::MIRROR_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mrrs_motor_table.sv =====
// Per-motor sweep state and reply snapshots; frame filtering, tick handling
// and request generation. Depends on mrrs_pkg.
`default_nettype none

module mrrs_motor_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_fire,
    input  wire mrrs_pkg::item_t                 item,
    input  wire logic [mrrs_pkg::ID_W-1:0]       feedback_base,
    input  wire logic [mrrs_pkg::ID_W-1:0]       command_base,
    output mrrs_pkg::mir_wr_t                    mir_wr,
    output mrrs_pkg::req_t                       req,
    output logic                                 motor_done
);

    logic [mrrs_pkg::STEP_W-1:0]  poll_step_reg [mrrs_pkg::NUM_MOTORS];
    logic                         pending_reg   [mrrs_pkg::NUM_MOTORS];
    logic [7:0]                   snap_reg_reg  [mrrs_pkg::NUM_MOTORS];
    logic [mrrs_pkg::WORD_W-1:0]  snap_val_reg  [mrrs_pkg::NUM_MOTORS];

    logic [mrrs_pkg::ID_W:0]      id_diff;
    logic                         frame_ok;
    logic [mrrs_pkg::MOTOR_W-1:0] frame_motor;
    logic                         mi_ok;
    logic [mrrs_pkg::STEP_W-1:0]  step_cur;
    logic [mrrs_pkg::SLOT_W:0]    snap_slot;
    logic                         store_ok;
    logic [mrrs_pkg::STEP_W-1:0]  step_next;
    logic                         tick_fire;
    logic                         frame_fire;

    always_comb
    begin
        id_diff     = {1'b0, item.frame_ident} - {1'b0, feedback_base};
        frame_motor = id_diff[mrrs_pkg::MOTOR_W-1:0];
        frame_ok    = item.frame_is_standard && item.frame_is_data
                      && item.frame_length == mrrs_pkg::FRAME_DLC
                      && !id_diff[mrrs_pkg::ID_W]
                      && id_diff[mrrs_pkg::ID_W-1:0] < mrrs_pkg::ID_W'(mrrs_pkg::NUM_MOTORS)
                      && item.command_byte == mrrs_pkg::REPLY_CODE;
        frame_fire  = item_fire && item.cmd == mrrs_pkg::CMD_FRAME && frame_ok;

        mi_ok      = item.motor_sel < mrrs_pkg::MOTOR_W'(mrrs_pkg::NUM_MOTORS);
        tick_fire  = item_fire && item.cmd == mrrs_pkg::CMD_TICK && mi_ok;
        step_cur   = mi_ok ? poll_step_reg[item.motor_sel] : mrrs_pkg::STEP_DONE;
        snap_slot  = mrrs_pkg::slot_lookup(mi_ok ? snap_reg_reg[item.motor_sel] : 8'd0);
        store_ok   = mi_ok && pending_reg[item.motor_sel]
                     && step_cur != mrrs_pkg::STEP_DONE && snap_slot[mrrs_pkg::SLOT_W];

        step_next = step_cur;
        if (store_ok)
        begin
            if (snap_slot[mrrs_pkg::SLOT_W-1:0] == mrrs_pkg::SLOT_LAST)
                step_next = mrrs_pkg::STEP_DONE;
            else
                step_next = mrrs_pkg::STEP_W'(snap_slot[mrrs_pkg::SLOT_W-1:0]) + 6'd2;
        end

        mir_wr.en   = tick_fire && store_ok;
        mir_wr.addr = mrrs_pkg::mirror_addr(item.motor_sel, snap_slot[mrrs_pkg::SLOT_W-1:0]);
        mir_wr.data = mi_ok ? snap_val_reg[item.motor_sel] : '0;

        req.valid   = tick_fire && step_next >= mrrs_pkg::STEP_FIRST
                      && step_next <= mrrs_pkg::STEP_LAST;
        req.can_id  = command_base + mrrs_pkg::ID_W'(item.motor_sel);
        req.reg_num = mrrs_pkg::register_of_step(step_next);

        motor_done  = mi_ok && step_cur == mrrs_pkg::STEP_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < mrrs_pkg::NUM_MOTORS; m++)
            begin
                poll_step_reg[m] <= mrrs_pkg::STEP_FIRST;
                pending_reg[m]   <= 1'b0;
            end
        end
        else
        begin
            if (frame_fire)
            begin
                pending_reg[frame_motor] <= 1'b1;
            end
            if (tick_fire)
            begin
                pending_reg[item.motor_sel]   <= 1'b0;
                poll_step_reg[item.motor_sel] <= step_next;
            end
        end
    end

    // snapshot payload; only observed after pending is set
    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            snap_reg_reg[frame_motor] <= item.register_number;
            snap_val_reg[frame_motor] <= item.payload_word;
        end
    end

`ifndef ASSERT_OFF
    a_store_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        mir_wr.en |-> tick_fire && !frame_fire)
        else $error("mirror write outside a poll tick");
    a_req_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> tick_fire && !mir_wr.en || tick_fire)
        else $error("request without poll tick");
    a_done_motor_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire && motor_done |-> !req.valid && !mir_wr.en)
        else $error("finished motor produced a request or store");
`endif

endmodule

`default_nettype wire

// ===== design/motor_register_readback_sequencer_core.sv =====
// Top level of the motor register read-back sequencer: stream ports, config,
// mirror clearing pass, read sequencing and output register. Uses mrrs_pkg,
// mrrs_mirror_ram and mrrs_motor_table.
`default_nettype none

// A poll tick's request goes straight into the output register; a mirror read
// passes the registered read port of the mirror RAM first. After reset the block
// clears its 270-word mirror, one word a cycle, and accepts no word until that
// pass ends (config writes are taken). The input is ready again once no mirror
// read is in flight and the output register is empty or being drained. Register
// read requests come out with kind 0, mirror data with kind 1.
module motor_register_readback_sequencer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // frame_ident, frame_is_standard, frame_is_data, frame_length, command_byte,
    // register_number, payload_word, motor_sel; zero pad to 72 bits
    input  wire logic [71:0] s_axis_tdata,
    // cmd
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // request_can_id, out_register, out_value, polling_done; zero pad to 56 bits
    output logic [55:0]      m_axis_tdata,
    // out_kind
    output logic             m_axis_tuser
);

    logic [mrrs_pkg::ID_W-1:0]    fb_base_reg;
    logic [mrrs_pkg::ID_W-1:0]    cmd_base_reg;
    logic                         clr_busy_reg;
    logic [mrrs_pkg::MIR_AW-1:0]  clr_cnt_reg;
    logic                         rd_busy_reg;
    logic [7:0]                   rd_reg_reg;
    logic                         rd_zero_reg;
    logic                         rd_done_reg;
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    logic [mrrs_pkg::ID_W-1:0]    out_id_reg;
    logic [7:0]                   out_regnum_reg;
    logic [mrrs_pkg::WORD_W-1:0]  out_value_reg;
    logic                         out_done_reg;

    mrrs_pkg::item_t              item;
    mrrs_pkg::mir_wr_t            mir_wr;
    mrrs_pkg::req_t               req;
    logic                         motor_done;
    logic                         item_fire;
    logic                         read_fire;
    logic [mrrs_pkg::SLOT_W:0]    rd_slot;
    logic                         rd_ok;
    logic                         ram_wr_en;
    logic [mrrs_pkg::MIR_AW-1:0]  ram_wr_addr;
    logic [mrrs_pkg::WORD_W-1:0]  ram_wr_data;
    logic [mrrs_pkg::MIR_AW-1:0]  ram_rd_addr;
    logic [mrrs_pkg::WORD_W-1:0]  ram_rd_data;
    logic                         out_free;

    always_comb
    begin
        item.cmd               = s_axis_tuser;
        item.frame_ident       = s_axis_tdata[10:0];
        item.frame_is_standard = s_axis_tdata[11];
        item.frame_is_data     = s_axis_tdata[12];
        item.frame_length      = s_axis_tdata[16:13];
        item.command_byte      = s_axis_tdata[24:17];
        item.register_number   = s_axis_tdata[32:25];
        item.payload_word      = s_axis_tdata[64:33];
        item.motor_sel         = s_axis_tdata[67:65];

        out_free      = !out_valid_reg || m_axis_tready;
        s_axis_tready = !clr_busy_reg && !rd_busy_reg && out_free;
        item_fire     = s_axis_tvalid && s_axis_tready;
        read_fire     = item_fire && item.cmd == mrrs_pkg::CMD_READ;

        rd_slot     = mrrs_pkg::slot_lookup(item.register_number);
        rd_ok       = rd_slot[mrrs_pkg::SLOT_W]
                      && item.motor_sel < mrrs_pkg::MOTOR_W'(mrrs_pkg::NUM_MOTORS);
        ram_rd_addr = mrrs_pkg::mirror_addr(item.motor_sel, rd_slot[mrrs_pkg::SLOT_W-1:0]);

        ram_wr_en   = clr_busy_reg || mir_wr.en;
        ram_wr_addr = clr_busy_reg ? clr_cnt_reg : mir_wr.addr;
        ram_wr_data = clr_busy_reg ? '0 : mir_wr.data;

        m_axis_tvalid = out_valid_reg;
        m_axis_tuser  = out_kind_reg;
        m_axis_tdata  = {4'd0, out_done_reg, out_value_reg, out_regnum_reg, out_id_reg};
    end

    mrrs_mirror_ram u_mirror (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (read_fire && rd_ok),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mrrs_motor_table u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_fire     (item_fire),
        .item          (item),
        .feedback_base (fb_base_reg),
        .command_base  (cmd_base_reg),
        .mir_wr        (mir_wr),
        .req           (req),
        .motor_done    (motor_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg   <= mrrs_pkg::FEEDBACK_BASE_RST;
            cmd_base_reg  <= mrrs_pkg::COMMAND_BASE_RST;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            rd_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    mrrs_pkg::CFG_FEEDBACK_BASE: fb_base_reg  <= cfg_wdata;
                    mrrs_pkg::CFG_COMMAND_BASE:  cmd_base_reg <= cfg_wdata;
                    default:                     fb_base_reg  <= fb_base_reg;
                endcase
            end

            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == mrrs_pkg::MIR_AW'(mrrs_pkg::MIRROR_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end

            rd_busy_reg <= read_fire;

            if (rd_busy_reg || req.valid)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // read context and output word payload
    always_ff @(posedge clk)
    begin
        if (read_fire)
        begin
            rd_reg_reg  <= item.register_number;
            rd_zero_reg <= !rd_ok;
            rd_done_reg <= motor_done;
        end
        if (rd_busy_reg)
        begin
            out_kind_reg   <= mrrs_pkg::KIND_READ;
            out_id_reg     <= '0;
            out_regnum_reg <= rd_reg_reg;
            out_value_reg  <= rd_zero_reg ? '0 : ram_rd_data;
            out_done_reg   <= rd_done_reg;
        end
        else if (req.valid)
        begin
            out_kind_reg   <= mrrs_pkg::KIND_REQUEST;
            out_id_reg     <= req.can_id;
            out_regnum_reg <= req.reg_num;
            out_value_reg  <= '0;
            out_done_reg   <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        rd_busy_reg |=> out_valid_reg && out_kind_reg == mrrs_pkg::KIND_READ)
        else $error("mirror read did not produce a word");
    a_clear_excl_store: assert property (@(posedge clk) disable iff (!rst_n)
        mir_wr.en |-> !clr_busy_reg)
        else $error("mirror store during clearing pass");
    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mir_wr.en |-> mir_wr.addr < mrrs_pkg::MIR_AW'(mrrs_pkg::MIRROR_DEPTH))
        else $error("mirror store address out of range");
    a_no_result_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rd_busy_reg |-> !req.valid && !out_valid_reg)
        else $error("result collides with pending mirror read");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_motor_register_readback_sequencer_core.sv =====
// Self-checking testbench for motor_register_readback_sequencer_core: directed
// and random frame, poll-tick and mirror-read traffic checked against a local
// prediction of the sweep state. Depends on mrrs_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_motor_register_readback_sequencer_core;

    typedef struct packed {
        logic        kind;
        logic [10:0] can_id;
        logic [7:0]  reg_num;
        logic [31:0] value;
        logic        done;
    } out_word_t;

    // cmd value with no meaning to the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_index     = mrrs_pkg::CFG_FEEDBACK_BASE;
    logic [10:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = mrrs_pkg::CMD_FRAME;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    // predicted block state
    logic [10:0] fb_base  = mrrs_pkg::FEEDBACK_BASE_RST;
    logic [10:0] cmd_base = mrrs_pkg::COMMAND_BASE_RST;
    int          sweep_step   [mrrs_pkg::NUM_MOTORS];
    logic        snap_pending [mrrs_pkg::NUM_MOTORS];
    logic [7:0]  snap_reg     [mrrs_pkg::NUM_MOTORS];
    logic [31:0] snap_value   [mrrs_pkg::NUM_MOTORS];
    logic [31:0] mirror_words [mrrs_pkg::NUM_MOTORS * mrrs_pkg::NUM_POLLED_REGS];

    out_word_t   pending_out_words[$];
    int          mismatch_count = 0;

    int          tx_idle_pct = 31;
    int          rx_idle_pct = 31;
    int          hold_req    = 0;
    int          hold_ack    = 0;
    int          hold_left   = 0;

    always #4 clk = ~clk;

    motor_register_readback_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack      <= hold_req;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // mirror slot of a register, -1 when the register is not in the sweep
    function automatic int reg_slot(input logic [7:0] r);
        if (r <= 8'd36)
            return int'(r);
        if (r >= 8'd50 && r <= 8'd55)
            return int'(r) - 13;
        if (r == 8'd80)
            return 43;
        if (r == 8'd81)
            return 44;
        return -1;
    endfunction

    function automatic logic [7:0] step_register(input int step);
        if (step <= 37)
            return 8'(step - 1);
        if (step <= 43)
            return 8'(step + 12);
        return 8'(step + 36);
    endfunction

    function automatic logic [71:0] pack_item(input mrrs_pkg::item_t it);
        logic [71:0] d;
        d        = '0;
        d[10:0]  = it.frame_ident;
        d[11]    = it.frame_is_standard;
        d[12]    = it.frame_is_data;
        d[16:13] = it.frame_length;
        d[24:17] = it.command_byte;
        d[32:25] = it.register_number;
        d[64:33] = it.payload_word;
        d[67:65] = it.motor_sel;
        return d;
    endfunction

    function automatic mrrs_pkg::item_t noise_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(mrrs_pkg::item_t)-1:0];
    endfunction

    function automatic mrrs_pkg::item_t reply_frame(input int m, input logic [7:0] r,
                                                    input logic [31:0] w);
        mrrs_pkg::item_t it;
        it                   = noise_item();
        it.cmd               = mrrs_pkg::CMD_FRAME;
        it.frame_ident       = 11'(fb_base + m);
        it.frame_is_standard = 1'b1;
        it.frame_is_data     = 1'b1;
        it.frame_length      = mrrs_pkg::FRAME_DLC;
        it.command_byte      = mrrs_pkg::REPLY_CODE;
        it.register_number   = r;
        it.payload_word      = w;
        return it;
    endfunction

    function automatic mrrs_pkg::item_t poll_tick(input int m);
        mrrs_pkg::item_t it;
        it           = noise_item();
        it.cmd       = mrrs_pkg::CMD_TICK;
        it.motor_sel = 3'(m);
        return it;
    endfunction

    function automatic mrrs_pkg::item_t mirror_read(input int m, input logic [7:0] r);
        mrrs_pkg::item_t it;
        it                 = noise_item();
        it.cmd             = mrrs_pkg::CMD_READ;
        it.motor_sel       = 3'(m);
        it.register_number = r;
        return it;
    endfunction

    // updates the predicted state for one accepted word, queues its result if it has one
    task automatic sweep_predict(input mrrs_pkg::item_t it);
        out_word_t w;
        int        m;
        int        slot;
        m = int'(it.motor_sel);
        w = '0;
        case (it.cmd)
            mrrs_pkg::CMD_FRAME:
            begin
                m = int'(it.frame_ident) - int'(fb_base);
                if (it.frame_is_standard && it.frame_is_data &&
                    it.frame_length == mrrs_pkg::FRAME_DLC &&
                    it.command_byte == mrrs_pkg::REPLY_CODE &&
                    m >= 0 && m < mrrs_pkg::NUM_MOTORS)
                begin
                    snap_reg[m]     = it.register_number;
                    snap_value[m]   = it.payload_word;
                    snap_pending[m] = 1'b1;
                end
            end
            mrrs_pkg::CMD_TICK:
            begin
                if (m < mrrs_pkg::NUM_MOTORS)
                begin
                    if (snap_pending[m])
                    begin
                        snap_pending[m] = 1'b0;
                        slot = reg_slot(snap_reg[m]);
                        if (sweep_step[m] != 0 && slot >= 0)
                        begin
                            mirror_words[m * mrrs_pkg::NUM_POLLED_REGS + slot] = snap_value[m];
                            sweep_step[m] = (slot == mrrs_pkg::NUM_POLLED_REGS - 1) ?
                                            0 : slot + 2;
                        end
                    end
                    if (sweep_step[m] != 0)
                    begin
                        w.kind    = mrrs_pkg::KIND_REQUEST;
                        w.can_id  = 11'(cmd_base + m);
                        w.reg_num = step_register(sweep_step[m]);
                        pending_out_words.push_back(w);
                    end
                end
            end
            mrrs_pkg::CMD_READ:
            begin
                w.kind    = mrrs_pkg::KIND_READ;
                w.reg_num = it.register_number;
                if (m < mrrs_pkg::NUM_MOTORS)
                begin
                    slot = reg_slot(it.register_number);
                    if (slot >= 0)
                        w.value = mirror_words[m * mrrs_pkg::NUM_POLLED_REGS + slot];
                    w.done = (sweep_step[m] == 0);
                end
                pending_out_words.push_back(w);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_out_word(input logic kind, input logic [55:0] d);
        out_word_t w;
        if (pending_out_words.size() == 0)
        begin
            report_mismatch("unexpected output word", d[31:0], 32'd0);
            return;
        end
        w = pending_out_words.pop_front();
        if (kind !== w.kind)
            report_mismatch("out_kind", kind, w.kind);
        if (d[10:0] !== w.can_id)
            report_mismatch("request_can_id", d[10:0], w.can_id);
        if (d[18:11] !== w.reg_num)
            report_mismatch("out_register", d[18:11], w.reg_num);
        if (d[50:19] !== w.value)
            report_mismatch("out_value", d[50:19], w.value);
        if (d[51] !== w.done)
            report_mismatch("polling_done", d[51], w.done);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_out_word(m_axis_tuser, m_axis_tdata);
    end

    // called at a rising edge; returns at the edge the word is taken
    task automatic send_word(input mrrs_pkg::item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sweep_predict(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_out_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [10:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == mrrs_pkg::CFG_FEEDBACK_BASE)
            fb_base = v;
        else
            cmd_base = v;
        @(posedge clk);
    endtask

    // one reply/tick exchange for a motor, mostly answering the register asked for
    task automatic poll_exchange(input int m);
        int         pick;
        logic [7:0] r;
        pick = $urandom_range(99);
        if (sweep_step[m] != 0 && pick < 80)
            r = step_register(sweep_step[m]);
        else if (pick < 90)
            r = step_register($urandom_range(mrrs_pkg::NUM_POLLED_REGS, 1));
        else if (pick < 92)
            r = 8'd81;
        else
            r = 8'($urandom_range(255));
        send_word(reply_frame(m, r, $urandom));
        if ($urandom_range(9) == 0)
            send_word(reply_frame(m, 8'($urandom_range(255)), $urandom));
        if ($urandom_range(3) == 0)
            send_word(mirror_read(m, r));
        send_word(poll_tick(m));
    endtask

    task automatic test_reset_and_special_cases();
        mrrs_pkg::item_t it;
        send_word(mirror_read(0, 8'd0));
        send_word(poll_tick(0));
        // each of these frames must be dropped
        it = reply_frame(0, 8'd0, 32'hDEAD_BEEF); it.frame_is_standard = 1'b0; send_word(it);
        it = reply_frame(0, 8'd0, 32'hDEAD_BEEF); it.frame_is_data = 1'b0;     send_word(it);
        it = reply_frame(0, 8'd0, 32'hDEAD_BEEF); it.frame_length = 4'd7;      send_word(it);
        it = reply_frame(0, 8'd0, 32'hDEAD_BEEF); it.frame_length = 4'd15;     send_word(it);
        it = reply_frame(0, 8'd0, 32'hDEAD_BEEF); it.command_byte = 8'h32;     send_word(it);
        send_word(reply_frame(-1, 8'd0, 32'hDEAD_BEEF));
        send_word(reply_frame(mrrs_pkg::NUM_MOTORS, 8'd0, 32'hDEAD_BEEF));
        send_word(poll_tick(0));
        send_word(reply_frame(5, 8'd0, 32'hFFFF_FFFF));
        send_word(poll_tick(5));
        send_word(mirror_read(5, 8'd0));
        // unknown register in the snapshot leaves the sweep where it is
        send_word(reply_frame(1, 8'd40, 32'h1234_5678));
        send_word(poll_tick(1));
        // last register ends the sweep
        send_word(reply_frame(2, 8'd81, 32'h8000_0001));
        send_word(poll_tick(2));
        send_word(mirror_read(2, 8'd81));
        send_word(poll_tick(6));
        send_word(poll_tick(7));
        send_word(mirror_read(7, 8'd0));
        it = noise_item(); it.cmd = CMD_UNUSED; send_word(it);
        send_word(mirror_read(0, 8'd255));
        drain();
    endtask

    task automatic test_config_extremes();
        write_cfg(mrrs_pkg::CFG_FEEDBACK_BASE, 11'd0);
        write_cfg(mrrs_pkg::CFG_COMMAND_BASE, 11'd2047);
        for (int m = 0; m < mrrs_pkg::NUM_MOTORS; m++)
            poll_exchange(m);
        drain();
        // no wrap of the feedback id past 2047; only motor 0 can answer
        write_cfg(mrrs_pkg::CFG_FEEDBACK_BASE, 11'd2047);
        write_cfg(mrrs_pkg::CFG_COMMAND_BASE, 11'd0);
        for (int m = 0; m < mrrs_pkg::NUM_MOTORS; m++)
            poll_exchange(m);
        send_word(reply_frame(0, 8'd3, $urandom));
        send_word(mirror_read(0, 8'd3));
        drain();
        write_cfg(mrrs_pkg::CFG_FEEDBACK_BASE, 11'd2042);
        write_cfg(mrrs_pkg::CFG_COMMAND_BASE, 11'd2044);
        for (int m = 0; m < mrrs_pkg::NUM_MOTORS; m++)
            poll_exchange(m);
        drain();
    endtask

    task automatic test_random_traffic();
        int pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_cfg(mrrs_pkg::CFG_FEEDBACK_BASE, 11'($urandom_range(2047)));
            write_cfg(mrrs_pkg::CFG_COMMAND_BASE, 11'($urandom_range(2047)));
            if (phase == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < 40; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    poll_exchange($urandom_range(mrrs_pkg::NUM_MOTORS - 1));
                else if (pick < 85)
                    send_word(mirror_read($urandom_range(7), 8'($urandom_range(255))));
                else
                    send_word(noise_item());
            end
            drain();
            tx_idle_pct = 31;
            rx_idle_pct = 31;
        end
    endtask

    task automatic test_output_backpressure();
        hold_req      <= hold_req + 1;
        tx_idle_pct = 0;
        for (int n = 0; n < 30; n++)
        begin
            if (n % 2 == 0)
                send_word(mirror_read($urandom_range(mrrs_pkg::NUM_MOTORS - 1),
                          step_register($urandom_range(mrrs_pkg::NUM_POLLED_REGS, 1))));
            else
                poll_exchange($urandom_range(mrrs_pkg::NUM_MOTORS - 1));
        end
        tx_idle_pct = 31;
        drain();
    endtask

    initial
    begin
        for (int m = 0; m < mrrs_pkg::NUM_MOTORS; m++)
        begin
            sweep_step[m]   = 1;
            snap_pending[m] = 1'b0;
            snap_reg[m]     = '0;
            snap_value[m]   = '0;
        end
        foreach (mirror_words[i])
            mirror_words[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_special_cases();
        test_config_extremes();
        test_random_traffic();
        test_output_backpressure();

        repeat (20) @(posedge clk);
        if (pending_out_words.size() != 0)
            report_mismatch("results never arrived", 32'd0, pending_out_words.size());
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== motor_register_readback_sequencer_core.f =====
design/mrrs_pkg.sv
design/mrrs_mirror_ram.sv
design/mrrs_motor_table.sv
design/motor_register_readback_sequencer_core.sv
dv/tb_motor_register_readback_sequencer_core.sv
